// ===== rtl/core/lpht_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package lpht_pkg;

    localparam int SLOTS_DEF         = 64;
    localparam int MAX_KEY_BYTES_DEF = 8;
    localparam int VALUE_BITS_DEF    = 64;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_FIND   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    localparam logic [0:0] REG_SLOTS_IN_USE = 1'd0;
    localparam logic [0:0] REG_MAX_ENTRIES  = 1'd1;

    typedef struct packed {
        logic [1:0]  command;
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
        logic [63:0] value_in;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value_out;
        logic [5:0]  slot_index;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture a new transaction
        logic hash_step;   // one FNV byte step
        logic mod_start;   // begin reduction of the hash
        logic mod_step;    // one restoring-division step
        logic probe_read;  // issue a slot read at the probe index
        logic advance;     // move probe index to the next slot
        logic commit;      // apply the write and form the result
    } lpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hash_done;
        logic mod_done;
        logic hit_free;    // slot never used
        logic hit_live;    // live matching key
        logic probe_last;  // every slot in use visited
    } lpht_sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/lpht_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_ctrl
    import lpht_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  lpht_sts_t      sts,
    output lpht_cmd_t      cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HASH  = 7'b0000010,
        S_MODST = 7'b0000100,
        S_MOD   = 7'b0001000,
        S_READ  = 7'b0010000,
        S_CHECK = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Output register lets a finished result wait while a new transaction arrives.
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Sequencer for hash, reduction and probe.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (sts.hash_done)
                begin
                    state_next = S_MODST;
                end
                else
                begin
                    cmd.hash_step = 1'b1;
                end
            end
            S_MODST:
            begin
                cmd.mod_start = 1'b1;
                state_next    = S_MOD;
            end
            S_MOD:
            begin
                if (sts.mod_done)
                begin
                    cmd.probe_read = 1'b1;
                    state_next     = S_CHECK;
                end
                else
                begin
                    cmd.mod_step = 1'b1;
                end
            end
            S_READ:
            begin
                cmd.probe_read = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.hit_free || sts.hit_live || sts.probe_last)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lpht_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module lpht_dp
    import lpht_pkg::*;
#(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  in_item_t       in_item,
    input  wire logic [6:0] slots_cfg,
    input  wire logic [6:0] max_cfg,
    input  lpht_cmd_t      cmd,
    output lpht_sts_t      sts,
    output out_item_t      out_item
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = IW + 1;
    localparam int KB = MAX_KEY_BYTES * 8;
    localparam int BW = $clog2(MAX_KEY_BYTES + 1);

    // Memories for keys, lengths and values; valid and tombstone bits in flops.
    logic [KB-1:0]         key_mem [SLOTS];
    logic [BW-1:0]         len_mem [SLOTS];
    logic [VALUE_BITS-1:0] val_mem [SLOTS];
    logic [SLOTS-1:0]      used_reg;
    logic [SLOTS-1:0]      tomb_reg;
    logic [CW-1:0]         live_reg;

    logic [1:0]            cmd_reg;
    logic [KB-1:0]         key_reg;
    logic [BW-1:0]         len_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [CW-1:0]         m_reg;
    logic [CW-1:0]         maxe_reg;
    logic [31:0]           hash_reg;
    logic [BW-1:0]         hcnt_reg;
    logic [31:0]           quo_reg;
    logic [CW-1:0]         rem_reg;
    logic [5:0]            mcnt_reg;
    logic                  mod_done_reg;
    logic [IW-1:0]         idx_reg;
    logic [CW-1:0]         ncnt_reg;
    logic [KB-1:0]         rd_key_reg;
    logic [BW-1:0]         rd_len_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic                  rd_used_reg;
    logic                  rd_tomb_reg;
    out_item_t             out_reg;

    logic [3:0]            len_sat;
    logic [BW-1:0]         len_in;
    logic [KB-1:0]         key_in;
    logic [7:0]            hbyte;
    logic [31:0]           hx;
    logic [CW:0]           rem_sh;
    logic [6:0]            m_in;
    logic                  hit_free;
    logic                  hit_live;
    logic [CW-1:0]         idx_inc;

    // Length saturation and key masking on capture.
    always_comb
    begin
        len_sat = (in_item.key_length > 4'(MAX_KEY_BYTES)) ? 4'(MAX_KEY_BYTES)
                                                          : in_item.key_length;
        len_in  = BW'(len_sat);
        for (int b = 0; b < MAX_KEY_BYTES; b++)
        begin
            key_in[b*8 +: 8] = (4'(b) < len_sat) ? in_item.key_bytes[b*8 +: 8] : 8'h00;
        end
        m_in = (slots_cfg == 7'd0) ? 7'd1 : slots_cfg;
    end

    assign hbyte  = key_reg[7:0];
    assign hx     = hash_reg ^ {24'd0, hbyte};
    assign rem_sh = {rem_reg, quo_reg[31]};

    assign hit_free = !rd_used_reg;
    assign hit_live = rd_used_reg && !rd_tomb_reg && (rd_len_reg == len_reg)
                      && (rd_key_reg == key_reg);
    assign idx_inc  = CW'(idx_reg) + CW'(1);

    assign sts.hash_done  = (hcnt_reg == len_reg);
    assign sts.mod_done   = mod_done_reg;
    assign sts.hit_free   = hit_free;
    assign sts.hit_live   = hit_live;
    assign sts.probe_last = (ncnt_reg == m_reg);
    assign out_item       = out_reg;

    // Capture, FNV steps, serial reduction and probe index.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg  <= in_item.command;
            key_reg  <= key_in;
            len_reg  <= len_in;
            val_reg  <= in_item.value_in[VALUE_BITS-1:0];
            m_reg    <= (int'(m_in) > SLOTS) ? CW'(SLOTS) : CW'(m_in);
            maxe_reg <= (int'(max_cfg) > SLOTS) ? CW'(SLOTS + 1) : CW'(max_cfg);
            hash_reg <= FNV_BASIS;
            hcnt_reg <= '0;
        end
        if (cmd.hash_step)
        begin
            hash_reg <= hx * FNV_PRIME;
            key_reg  <= {key_reg[7:0], key_reg[KB-1:8]};
            hcnt_reg <= hcnt_reg + BW'(1);
        end
        if (cmd.mod_start)
        begin
            quo_reg      <= hash_reg;
            rem_reg      <= '0;
            mcnt_reg     <= '0;
            mod_done_reg <= 1'b0;
            // Restore key byte order after rotating through len bytes.
            for (int r = 0; r <= MAX_KEY_BYTES; r++)
            begin
                if (BW'(r) == len_reg)
                begin
                    key_reg <= (KB)'((key_reg >> ((KB - 8*r) % KB))
                               | (key_reg << ((8*r) % KB)));
                end
            end
        end
        if (cmd.mod_step)
        begin
            quo_reg <= {quo_reg[30:0], 1'b0};
            if (rem_sh >= {1'b0, m_reg})
            begin
                rem_reg <= CW'(rem_sh - {1'b0, m_reg});
            end
            else
            begin
                rem_reg <= CW'(rem_sh);
            end
            mcnt_reg     <= mcnt_reg + 6'd1;
            mod_done_reg <= (mcnt_reg == 6'd31);
        end
        if (cmd.probe_read && !cmd.advance && cmd.mod_step == 1'b0 && sts.mod_done
            && ncnt_reg == '0)
        begin
            idx_reg <= IW'(rem_reg);
        end
        if (cmd.advance)
        begin
            idx_reg <= (idx_inc == m_reg) ? '0 : IW'(idx_inc);
        end
    end

    // Probe read path: slot contents registered.
    always_ff @(posedge clk)
    begin
        if (cmd.probe_read)
        begin
            rd_key_reg  <= key_mem[sts.mod_done && ncnt_reg == '0 ? IW'(rem_reg) : idx_reg];
            rd_len_reg  <= len_mem[sts.mod_done && ncnt_reg == '0 ? IW'(rem_reg) : idx_reg];
            rd_val_reg  <= val_mem[sts.mod_done && ncnt_reg == '0 ? IW'(rem_reg) : idx_reg];
            rd_used_reg <= used_reg[sts.mod_done && ncnt_reg == '0 ? IW'(rem_reg) : idx_reg];
            rd_tomb_reg <= tomb_reg[sts.mod_done && ncnt_reg == '0 ? IW'(rem_reg) : idx_reg];
        end
        if (cmd.commit && cmd_reg == CMD_INSERT && (hit_live || hit_free && live_reg < maxe_reg))
        begin
            val_mem[idx_reg] <= val_reg;
            if (!hit_live)
            begin
                key_mem[idx_reg] <= key_reg;
                len_mem[idx_reg] <= len_reg;
            end
        end
    end

    // Probe counter, flags and live count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            tomb_reg <= '0;
            live_reg <= '0;
            ncnt_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                ncnt_reg <= '0;
            end
            if (cmd.probe_read)
            begin
                ncnt_reg <= ncnt_reg + CW'(1);
            end
            if (cmd.commit)
            begin
                if (cmd_reg == CMD_INSERT && hit_free && live_reg < maxe_reg)
                begin
                    used_reg[idx_reg] <= 1'b1;
                    tomb_reg[idx_reg] <= 1'b0;
                    live_reg          <= live_reg + CW'(1);
                end
                if (cmd_reg == CMD_REMOVE && hit_live)
                begin
                    tomb_reg[idx_reg] <= 1'b1;
                    if (live_reg != '0)
                    begin
                        live_reg <= live_reg - CW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.status     <= ST_ABSENT;
            out_reg.value_out  <= '0;
            out_reg.slot_index <= '0;
            if (cmd_reg == CMD_INSERT || cmd_reg == CMD_FIND || cmd_reg == CMD_REMOVE)
            begin
                if (!hit_free && !hit_live)
                begin
                    out_reg.status <= ST_FULL;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    if (hit_live || live_reg < maxe_reg)
                    begin
                        out_reg.status     <= ST_DONE;
                        out_reg.slot_index <= 6'(idx_reg);
                    end
                    else
                    begin
                        out_reg.status <= ST_FULL;
                    end
                end
                else if (hit_live)
                begin
                    out_reg.status     <= ST_DONE;
                    out_reg.slot_index <= 6'(idx_reg);
                    if (cmd_reg == CMD_FIND)
                    begin
                        out_reg.value_out <= 64'(rd_val_reg);
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/linear_probe_hash_table_top.sv =====
// Transactions are processed one at a time; the FNV byte loop, the 32-step serial
// modulo and the one-slot-per-probe memory read run in sequence for each.
// Reset: asynchronous active low; clears used/tombstone bits and live count,
// slots_in_use to 64 and max_entries to 48. Key and value memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module linear_probe_hash_table_top
    import lpht_pkg::*;
#(
    parameter int SLOTS         = SLOTS_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int VALUE_BITS    = VALUE_BITS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  in_item_t        in_data,
    output logic            out_valid,
    input  wire logic       out_ready,
    output out_item_t       out_data,
    input  wire logic       cfg_we,
    input  wire logic [0:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    logic [6:0] slots_reg;
    logic [6:0] maxe_reg;
    lpht_cmd_t  cmd;
    lpht_sts_t  sts;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= 7'd64;
            maxe_reg  <= 7'd48;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SLOTS_IN_USE: slots_reg <= cfg_data;
                REG_MAX_ENTRIES:  maxe_reg  <= cfg_data;
                default:          slots_reg <= slots_reg;
            endcase
        end
    end

    lpht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    lpht_dp #(
        .SLOTS         (SLOTS),
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .VALUE_BITS    (VALUE_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_data),
        .slots_cfg (slots_reg),
        .max_cfg   (maxe_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_item  (out_data)
    );

endmodule
`default_nettype wire

// ===== dv/linear_probe_hash_table_top_test.sv =====
`timescale 1ns / 1ps
module linear_probe_hash_table_top_test;
    import lpht_pkg::*;

    localparam int NUM_SLOTS = 64;
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [0:0] cfg_index = REG_SLOTS_IN_USE;
    logic [6:0] cfg_data = '0;

    linear_probe_hash_table_top uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Shadow copy of the table contents and its configuration.
    logic [63:0] tbl_keys [NUM_SLOTS];
    logic [3:0] tbl_lens [NUM_SLOTS];
    logic [63:0] tbl_vals [NUM_SLOTS];
    bit tbl_used [NUM_SLOTS];
    bit tbl_tomb [NUM_SLOTS];
    int unsigned live_entries;
    int unsigned modulus_reg;
    int unsigned entry_limit;

    in_item_t pending_ops[$];
    out_item_t expected_answers[$];
    int unsigned errors = 0;
    int unsigned cycles = 0;
    bit hold_sender = 1'b0;
    int unsigned tx_gap = 0;
    int unsigned rx_gap = 0;

    function automatic logic [31:0] fnv_hash(logic [63:0] key, int unsigned len);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int i = 0; i < len; i++)
        begin
            h = h ^ {24'd0, key[8*i +: 8]};
            h = h * FNV_PRIME;
        end
        return h;
    endfunction

    // Apply one operation to the shadow table and return its answer.
    function automatic out_item_t table_apply(in_item_t op);
        out_item_t res;
        int unsigned len, m, idx;
        logic [63:0] key;
        bit found, live;
        res = '0;
        res.status = ST_ABSENT;
        found = 0;
        live = 0;
        len = (op.key_length > 8) ? 8 : op.key_length;
        key = (len >= 8) ? op.key_bytes : (op.key_bytes & ((64'd1 << (8*len)) - 1));
        m = (modulus_reg == 0) ? 1 : (modulus_reg > NUM_SLOTS ? NUM_SLOTS : modulus_reg);
        if (op.command > CMD_REMOVE)
            return res;
        idx = fnv_hash(key, len) % m;
        for (int n = 0; n < m; n++)
        begin
            if (!tbl_used[idx])
            begin
                found = 1;
                break;
            end
            if (!tbl_tomb[idx] && tbl_lens[idx] == len && tbl_keys[idx] == key)
            begin
                found = 1;
                live = 1;
                break;
            end
            idx = (idx + 1) % m;
        end
        if (!found)
            res.status = ST_FULL;
        else if (op.command == CMD_INSERT)
        begin
            if (live)
            begin
                tbl_vals[idx] = op.value_in;
                res.status = ST_DONE;
                res.slot_index = idx[5:0];
            end
            else if (live_entries >= entry_limit)
                res.status = ST_FULL;
            else
            begin
                tbl_keys[idx] = key;
                tbl_lens[idx] = len[3:0];
                tbl_vals[idx] = op.value_in;
                tbl_used[idx] = 1;
                tbl_tomb[idx] = 0;
                live_entries++;
                res.status = ST_DONE;
                res.slot_index = idx[5:0];
            end
        end
        else if (live)
        begin
            res.status = ST_DONE;
            res.slot_index = idx[5:0];
            if (op.command == CMD_FIND)
                res.value_out = tbl_vals[idx];
            else
            begin
                tbl_tomb[idx] = 1;
                if (live_entries > 0)
                    live_entries--;
            end
        end
        return res;
    endfunction

    function automatic int unsigned pick_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
    endfunction

    // Driver: presents queued operations and predicts each accepted one.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_answers.push_back(table_apply(in_data));
            if (!(in_valid && !in_ready))
            begin
                if (tx_gap > 0)
                begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_ops.size() > 0 && !hold_sender)
                begin
                    in_data <= pending_ops.pop_front();
                    in_valid <= 1'b1;
                    tx_gap <= pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each delivered transaction against the oldest prediction.
    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    $error("unexpected result transaction");
                    errors++;
                end
                else
                begin
                    exp_res = expected_answers.pop_front();
                    if (out_data.status !== exp_res.status)
                    begin
                        $error("status exp %0d got %0d", exp_res.status, out_data.status);
                        errors++;
                    end
                    if (out_data.value_out !== exp_res.value_out)
                    begin
                        $error("value_out exp %h got %h", exp_res.value_out, out_data.value_out);
                        errors++;
                    end
                    if (out_data.slot_index !== exp_res.slot_index)
                    begin
                        $error("slot_index exp %0d got %0d", exp_res.slot_index,
                               out_data.slot_index);
                        errors++;
                    end
                end
            end
            if (rx_gap > 0)
            begin
                rx_gap <= rx_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!out_ready || (out_valid && out_ready))
                    rx_gap <= pick_gap();
            end
        end
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("linear_probe_hash_table_top_test NOT OK");
            $finish;
        end
    end

    function automatic in_item_t make_op(logic [1:0] cmd, logic [63:0] key,
                                          logic [3:0] len, logic [63:0] val);
        in_item_t op;
        op.command = cmd;
        op.key_bytes = key;
        op.key_length = len;
        op.value_in = val;
        return op;
    endfunction

    // Keys from a small pool so inserts, finds and removes meet each other.
    function automatic in_item_t random_op(int unsigned pool);
        int unsigned sel, r;
        logic [63:0] k;
        logic [1:0] c;
        sel = $urandom_range(0, pool);
        k = {32'h9e3779b9 * sel, 32'h85ebca6b ^ sel};
        if ($urandom_range(0, 9) == 0)
            k = {$urandom, $urandom};
        r = $urandom_range(0, 19);
        c = (r < 9) ? CMD_INSERT : (r < 15) ? CMD_FIND : (r < 19) ? CMD_REMOVE : CMD_UNUSED;
        return make_op(c, k, (sel % 9 == 0) ? 4'($urandom_range(0, 15)) : 4'(1 + sel % 8),
                       {$urandom, $urandom});
    endfunction

    task automatic drain_all();
        while (pending_ops.size() > 0 || in_valid || expected_answers.size() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [6:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_SLOTS_IN_USE)
            modulus_reg = val;
        else
            entry_limit = val;
        @(posedge clk);
    endtask

    initial
    begin
        int unsigned modulus_set [6] = '{64, 1, 0, 127, 7, 20};
        int unsigned limit_set [6] = '{64, 0, 3, 127, 5, 12};
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_used[i] = 0;
            tbl_tomb[i] = 0;
            tbl_keys[i] = '0;
            tbl_lens[i] = '0;
            tbl_vals[i] = '0;
        end
        live_entries = 0;
        modulus_reg = 64;
        entry_limit = 48;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes, every command, long and empty keys.
        pending_ops.push_back(make_op(CMD_FIND, 64'h1, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_REMOVE, 64'h1, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_INSERT, '1, 4'd8, '1));
        pending_ops.push_back(make_op(CMD_FIND, '1, 4'd8, '0));
        pending_ops.push_back(make_op(CMD_FIND, '1, 4'd15, '0));
        pending_ops.push_back(make_op(CMD_INSERT, 64'hFFFF_FF00, 4'd0, 64'h5));
        pending_ops.push_back(make_op(CMD_FIND, 64'h0, 4'd0, '1));
        pending_ops.push_back(make_op(CMD_INSERT, 64'hAB, 4'd1, 64'h0));
        pending_ops.push_back(make_op(CMD_INSERT, 64'hAB, 4'd1, 64'h77));
        pending_ops.push_back(make_op(CMD_FIND, 64'hFFAB, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_INSERT, 64'h00AB, 4'd2, 64'h3));
        pending_ops.push_back(make_op(CMD_REMOVE, 64'hAB, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_FIND, 64'hAB, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_REMOVE, 64'hAB, 4'd1, '0));
        pending_ops.push_back(make_op(CMD_INSERT, 64'hAB, 4'd1, 64'h9));
        pending_ops.push_back(make_op(CMD_UNUSED, '1, 4'd8, '1));
        pending_ops.push_back(make_op(CMD_FIND, 64'h00AB, 4'd2, '0));
        drain_all();

        // Random phases across register settings, including the extremes.
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_SLOTS_IN_USE, 7'(modulus_set[p]));
            write_reg(REG_MAX_ENTRIES, 7'(limit_set[p]));
            for (int i = 0; i < 140; i++)
                pending_ops.push_back(random_op(p == 0 ? 90 : 30));
            if (p == 2)
            begin
                while (pending_ops.size() > 70)
                    @(posedge clk);
                hold_sender = 1'b1;
                while (in_valid || expected_answers.size() > 0)
                    @(posedge clk);
                hold_sender = 1'b0;
            end
            drain_all();
        end

        if (errors == 0)
            $display("linear_probe_hash_table_top_test OK");
        else
            $display("linear_probe_hash_table_top_test NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/lpht_pkg.sv
rtl/core/lpht_ctrl.sv
rtl/core/lpht_dp.sv
rtl/core/linear_probe_hash_table_top.sv
dv/linear_probe_hash_table_top_test.sv
